/* rtl/core/mtd_pkg.sv */
`timescale 1ns / 1ps

package mtd_pkg;

    // generator constants
    localparam int MT_M            = 397;
    localparam logic [31:0] MT_MULT   = 32'd1812433253;
    localparam logic [31:0] MT_MATRIX = 32'h9908B0DF;
    localparam logic [31:0] TEMPER_B  = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C  = 32'hEFC60000;

    // trailer format
    localparam logic [31:0] TRAILER_MARKER = {8'h1C, 8'hAC, 8'h00, 8'h01};
    localparam logic [31:0] TRAILER_BYTES  = 32'd8;

    // keystream and scramble span
    localparam int KEY_WORDS      = 8;
    localparam int SCRAMBLE_BYTES = 2048;

    localparam int KIDX_W  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int LO_W    = $clog2(KEY_WORDS + 1);
    localparam int STEP_W  = $clog2(MT_M + KEY_WORDS);
    localparam int SPAN_W  = $clog2(SCRAMBLE_BYTES + 1);
    localparam int LIMIT_W = $clog2(SCRAMBLE_BYTES / 4 + 1);

    // keystream write port from the generator to the core
    typedef struct packed {
        logic              we;
        logic [KIDX_W-1:0] idx;
        logic [31:0]       data;
    } t_key_wr;

    function automatic logic [31:0] mt_temper(input logic [31:0] y_in);
        logic [31:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

/* rtl/core/mtd_keygen.sv */
`timescale 1ns / 1ps

module mtd_keygen (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_seed,
    output mtd_pkg::t_key_wr     o_key_wr,
    output logic                 o_done
);

    typedef enum logic [2:0] {
        KG_IDLE = 3'b001,
        KG_MUL  = 3'b010,
        KG_ADD  = 3'b100
    } t_kg_state;

    localparam logic [mtd_pkg::STEP_W-1:0] FirstTwist =
        mtd_pkg::STEP_W'(mtd_pkg::MT_M);
    localparam logic [mtd_pkg::STEP_W-1:0] LastStep =
        mtd_pkg::STEP_W'(mtd_pkg::MT_M + mtd_pkg::KEY_WORDS - 1);
    localparam logic [mtd_pkg::STEP_W-1:0] LastLow =
        mtd_pkg::STEP_W'(mtd_pkg::KEY_WORDS);

    t_kg_state                   r_state, n_state;
    logic [mtd_pkg::STEP_W-1:0]  r_i;
    logic [31:0]                 r_p;
    logic [31:0]                 r_prod;
    logic [31:0]                 r_lo [mtd_pkg::KEY_WORDS+1];

    logic [31:0] w_v;
    logic [31:0] w_y;
    logic [31:0] w_x;

    // one seeding step: multiply, then add the index
    assign w_v = r_prod + 32'(r_i);
    assign w_y = {r_lo[0][31], r_lo[1][30:0]};
    assign w_x = w_v ^ (w_y >> 1) ^ (w_y[0] ? mtd_pkg::MT_MATRIX : 32'd0);

    always_comb begin
        o_key_wr.we   = (r_state == KG_ADD) && (r_i >= FirstTwist);
        o_key_wr.idx  = mtd_pkg::KIDX_W'(r_i - FirstTwist);
        o_key_wr.data = mtd_pkg::mt_temper(w_x);
        o_done        = (r_state == KG_ADD) && (r_i == LastStep);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            KG_IDLE: if (i_start) n_state = KG_MUL;
            KG_MUL:  n_state = KG_ADD;
            KG_ADD:  n_state = (r_i == LastStep) ? KG_IDLE : KG_MUL;
            default: n_state = KG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KG_IDLE;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == KG_IDLE && i_start) begin
                r_i <= mtd_pkg::STEP_W'(1);
            end else if (r_state == KG_ADD) begin
                r_i <= r_i + mtd_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == KG_IDLE && i_start) begin
            r_p      <= i_seed;
            r_lo[0]  <= i_seed;
        end
        if (r_state == KG_MUL) begin
            r_prod <= 32'(mtd_pkg::MT_MULT * (r_p ^ (r_p >> 30)));
        end
        if (r_state == KG_ADD) begin
            r_p <= w_v;
            if (r_i <= LastLow) begin
                r_lo[r_i[mtd_pkg::LO_W-1:0]] <= w_v;
            end
            // low words slide down as each keystream word is formed
            if (r_i >= FirstTwist) begin
                for (int j = 0; j < mtd_pkg::KEY_WORDS; j++) begin
                    r_lo[j] <= r_lo[j+1];
                end
            end
        end
    end

endmodule

/* rtl/core/mt19937_trailer_descrambler_core.sv */
`timescale 1ns / 1ps

// trailer-keyed descrambler. send a trailer word first (opcode 0) with the seed, marker
// and file length; it answers with one status word, scrambled_file set when the marker
// reads 1C AC 00 01 and the length is at least 8. on a match the block seeds an mt19937
// generator and keeps its first KEY_WORDS tempered outputs as the keystream; each seeding
// step uses the single 32x32 multiplier, a multiply state then an add state, and no word
// is accepted while seeding runs. an unmatched trailer skips seeding.
// payload words (opcode 1) are then accepted back to back unless the output stalls.
// the first ceil(min(SCRAMBLE_BYTES, length - 8) / 4) words are xored with the keystream
// in rotation, later words pass unchanged. a new trailer restarts the word count.
module mt19937_trailer_descrambler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [31:0] i_seed_word,
    input  logic [31:0] i_marker_word,
    input  logic [31:0] i_file_length,
    input  logic [31:0] i_payload_word,

    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [31:0] o_word_out,
    output logic        o_scrambled_file
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEED   = 3'b010,
        S_STATUS = 3'b100
    } t_core_state;

    localparam logic OP_TRAILER = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    localparam logic [mtd_pkg::KIDX_W-1:0] LastKey =
        mtd_pkg::KIDX_W'(mtd_pkg::KEY_WORDS - 1);
    localparam logic [31:0] ScrambleMax = 32'(mtd_pkg::SCRAMBLE_BYTES);

    t_core_state                  r_state;
    logic                         r_en;
    logic [mtd_pkg::LIMIT_W-1:0]  r_idx;
    logic [mtd_pkg::LIMIT_W-1:0]  r_lim;
    logic [mtd_pkg::KIDX_W-1:0]   r_kidx;
    logic [31:0]                  r_key [mtd_pkg::KEY_WORDS];

    // output register
    logic        r_out_valid;
    logic        r_kind;
    logic [31:0] r_word;
    logic        r_flag;

    mtd_pkg::t_key_wr w_key_wr;
    logic             w_kg_done;
    logic             w_out_free;
    logic             w_out_load;
    logic             w_accept;
    logic             w_match;
    logic [31:0]      w_body;
    logic [mtd_pkg::SPAN_W-1:0]  w_span;
    logic [mtd_pkg::SPAN_W:0]    w_span_up;
    logic [mtd_pkg::LIMIT_W-1:0] w_limit;
    logic             w_xor;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;

    // trailer decode and word limit
    assign w_match   = (i_file_length >= mtd_pkg::TRAILER_BYTES) &&
                       (i_marker_word == mtd_pkg::TRAILER_MARKER);
    assign w_body    = i_file_length - mtd_pkg::TRAILER_BYTES;
    assign w_span    = (w_body < ScrambleMax) ? mtd_pkg::SPAN_W'(w_body)
                                              : mtd_pkg::SPAN_W'(ScrambleMax);
    assign w_span_up = {1'b0, w_span} + (mtd_pkg::SPAN_W+1)'(3);
    assign w_limit   = mtd_pkg::LIMIT_W'(w_span_up >> 2);

    // payload word inside the scrambled span
    assign w_xor = r_en && (r_idx < r_lim);

    // a result word enters the output register: payload, unmatched trailer, or matched status
    assign w_out_load = (w_accept && !((i_opcode == OP_TRAILER) && w_match)) ||
                        ((r_state == S_STATUS) && w_out_free);

    mtd_keygen u_keygen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept && (i_opcode == OP_TRAILER) && w_match),
        .i_seed   (i_seed_word),
        .o_key_wr (w_key_wr),
        .o_done   (w_kg_done)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_en        <= 1'b0;
            r_idx       <= '0;
            r_lim       <= '0;
            r_kidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_opcode == OP_TRAILER) begin
                            r_idx  <= '0;
                            r_kidx <= '0;
                            r_en   <= w_match;
                            r_lim  <= w_match ? w_limit : '0;
                            if (w_match) begin
                                r_state <= S_SEED;
                            end
                        end else begin
                            if (w_xor) begin
                                r_idx  <= r_idx + mtd_pkg::LIMIT_W'(1);
                                r_kidx <= (r_kidx == LastKey) ? '0
                                          : r_kidx + mtd_pkg::KIDX_W'(1);
                            end
                        end
                    end
                end
                S_SEED: begin
                    if (w_kg_done) r_state <= S_STATUS;
                end
                S_STATUS: begin
                    // matched trailer status waits for a free output register
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            if (i_opcode == OP_TRAILER) begin
                r_kind <= OP_TRAILER;
                r_word <= '0;
                r_flag <= 1'b0;
            end else begin
                r_kind <= OP_PAYLOAD;
                r_word <= w_xor ? (i_payload_word ^ r_key[r_kidx]) : i_payload_word;
                r_flag <= r_en;
            end
        end else if (r_state == S_STATUS && w_out_free) begin
            r_kind <= OP_TRAILER;
            r_word <= '0;
            r_flag <= 1'b1;
        end
    end

    // keystream store
    always_ff @(posedge i_clk) begin
        if (w_key_wr.we) begin
            r_key[w_key_wr.idx] <= w_key_wr.data;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_word_out       = r_word;
    assign o_scrambled_file = r_flag;

    // the running index never passes the word limit
    a_idx_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_lim)
        else $error("word index beyond limit");

    // keystream is written only while seeding
    a_key_wr_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_key_wr.we |-> (r_state == S_SEED))
        else $error("keystream write outside seeding");

    // seeding ends in the status state
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_kg_done |=> (r_state == S_STATUS))
        else $error("seeding done without status");

    // a matched trailer enables descrambling and starts seeding
    a_match_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == OP_TRAILER) && w_match) |=>
            ((r_state == S_SEED) && r_en && (r_idx == '0)))
        else $error("matched trailer did not start seeding");

endmodule
